/* rtl/sdro_pkg.sv */
// Shared types, constants and helpers of the disk request ordering block.
`default_nettype none

package sdro_pkg;

  localparam int unsigned MaxRequestsDef = 32;
  localparam int unsigned CylW           = 16;
  localparam int unsigned TotalW         = 21;
  localparam int unsigned MsW            = 8;
  localparam int unsigned TimeW          = 29;
  localparam int unsigned OutDataW       = 88;

  localparam logic [MsW-1:0]    MsReset    = 8'd6;
  localparam logic [TotalW-1:0] TotalLimit = 21'h1FFFFF;

  // One result as it leaves the scheduler, before the time is scaled.
  typedef struct packed {
    logic              last;
    logic [TotalW-1:0] total;
    logic [CylW-1:0]   seek;
    logic [CylW-1:0]   served;
  } res_t;

  // Absolute distance between two cylinders.
  function automatic logic [CylW-1:0] gap(input logic [CylW-1:0] a, input logic [CylW-1:0] b);
    gap = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

/* rtl/sdro_store.sv */
// Request store: one write port and one registered read port.
`default_nettype none

module sdro_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AddrW-1:0]           waddr_i,
  input  wire logic [sdro_pkg::CylW-1:0]  wdata_i,
  input  wire logic [AddrW-1:0]           raddr_i,
  output      logic [sdro_pkg::CylW-1:0]  rdata_o
);
  import sdro_pkg::*;

  logic [CylW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/sdro_out.sv */
// Output register: scales the running total into seek time and holds the result.
`default_nettype none

module sdro_out (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [sdro_pkg::MsW-1:0]     ms_i,
  input  wire logic                         load_i,
  input  wire sdro_pkg::res_t               res_i,
  output      logic                         ready_o,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [sdro_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic                         m_axis_tlast
);
  import sdro_pkg::*;

  logic             valid_q;
  logic [TimeW-1:0] time_d;
  logic             taken;

  assign taken   = valid_q & m_axis_tready;
  assign ready_o = ~valid_q | m_axis_tready;
  assign time_d  = TimeW'(res_i.total) * TimeW'(ms_i);

  // Valid flag of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (taken) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, packed from the lowest bit up.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      m_axis_tdata <= {6'd0, time_d, res_i.total, res_i.seek, res_i.served};
      m_axis_tlast <= res_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;

endmodule

`default_nettype wire

/* rtl/sstf_disk_request_order.sv */
// Top level: shortest seek time first ordering of a batch of cylinder requests.
//
// Requests arrive on the slave stream (tdata = cylinder, tlast = last of batch),
// one transfer per cycle while a batch is loading. A batch closes at tlast or
// when the store fills with MAX_REQUESTS entries. The block then stops taking
// requests and emits one result per request, in service order, on the master
// stream: served cylinder, seek distance, running total and seek time (total
// times ms_per_cylinder). The head starts at the first request; at each step
// the remaining requests are stably reordered by distance from the head by an
// insertion sort that runs over the request store. Emitting a result reads the
// next entry, forms its distance and total, then loads the output register;
// the sort after it inserts each of the other remaining requests in turn,
// reading it, then shifting each farther entry up one place and writing it
// in place. The single output register lets the next step run while a result
// waits; a stall on m_axis_tready halts the sequencer only when a new result
// is ready. Reset clears the request count, the head, the running total and
// the output, and sets ms_per_cylinder to 6; the store itself is not cleared.
// The configuration write is taken at any edge with cfg_we_i high.
`default_nettype none

module sstf_disk_request_order #(
  parameter int unsigned MAX_REQUESTS = sdro_pkg::MaxRequestsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sdro_pkg::MsW-1:0]      cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // [15:0] cylinder
  input  wire logic [sdro_pkg::CylW-1:0]     s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [15:0] served_cylinder, [31:16] seek_distance, [52:32] total_distance,
  // [81:53] seek_time_ms, [87:82] zero
  output      logic [sdro_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic                          m_axis_tlast
);
  import sdro_pkg::*;

  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ER   = 3'd1;
  localparam logic [2:0] S_ED   = 3'd2;
  localparam logic [2:0] S_EM   = 3'd3;
  localparam logic [2:0] S_SI   = 3'd4;
  localparam logic [2:0] S_SV   = 3'd5;
  localparam logic [2:0] S_SC   = 3'd6;
  localparam logic [2:0] S_SW   = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d, n_q, n_d;
  logic [AW-1:0]   k_q, k_d, i_q, i_d, j_q, j_d;
  logic [CylW-1:0] head_q, head_d, v_q, v_d, d_q, d_d;
  logic [TotalW-1:0] sum_q, sum_d;
  logic [MsW-1:0]  ms_q;
  res_t            res_q, res_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [CylW-1:0] mem_wdata, mem_rdata;
  logic            out_ready, out_load;
  logic            in_take;
  logic [TotalW:0] sum_wide;
  logic [CylW-1:0] rd_gap;

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign rd_gap        = gap(mem_rdata, head_q);
  assign sum_wide      = {1'b0, sum_q} + {{(TotalW + 1 - CylW){1'b0}}, rd_gap};

  sdro_store #(
    .Depth (MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sdro_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ms_i          (ms_q),
    .load_i        (out_load),
    .res_i         (res_q),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MsReset;
    end else if (cfg_we_i) begin
      ms_q <= cfg_wdata_i;
    end
  end

  // Sequencer: load, emit the next request, then stably insertion-sort the rest.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    head_d    = head_q;
    v_d       = v_q;
    d_d       = d_q;
    sum_d     = sum_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = v_q;
    mem_raddr = k_q;
    out_load  = 1'b0;
    case (state_q)
      S_LOAD: begin
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = s_axis_tdata;
        if (in_take) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          if (s_axis_tlast || (cnt_q + CW'(1) == CW'(MAX_REQUESTS))) begin
            n_d     = cnt_q + CW'(1);
            cnt_d   = '0;
            k_d     = '0;
            state_d = S_ER;
          end
        end
      end
      S_ER: begin
        mem_raddr = k_q;
        state_d   = S_ED;
      end
      S_ED: begin
        res_d.served = mem_rdata;
        res_d.last   = ({{(CW - AW){1'b0}}, k_q} + CW'(1) == n_q);
        if (k_q == '0) begin
          res_d.seek = '0;
          sum_d      = '0;
        end else begin
          res_d.seek = rd_gap;
          sum_d      = sum_wide[TotalW] ? TotalLimit : sum_wide[TotalW-1:0];
        end
        res_d.total = (k_q == '0) ? '0 :
                      (sum_wide[TotalW] ? TotalLimit : sum_wide[TotalW-1:0]);
        head_d  = mem_rdata;
        state_d = S_EM;
      end
      S_EM: begin
        if (out_ready) begin
          out_load = 1'b1;
          if (res_q.last) begin
            head_d  = '0;
            sum_d   = '0;
            state_d = S_LOAD;
          end else begin
            k_d = k_q + AW'(1);
            if ({{(CW - AW){1'b0}}, k_q} + CW'(2) < n_q) begin
              i_d     = k_q + AW'(2);
              state_d = S_SI;
            end else begin
              state_d = S_ER;
            end
          end
        end
      end
      S_SI: begin
        mem_raddr = i_q;
        state_d   = S_SV;
      end
      S_SV: begin
        v_d       = mem_rdata;
        d_d       = rd_gap;
        j_d       = i_q;
        mem_raddr = i_q - AW'(1);
        state_d   = S_SC;
      end
      S_SC: begin
        mem_we = 1'b1;
        if (rd_gap > d_q) begin
          // Shift the farther entry up one place.
          mem_wdata = mem_rdata;
          j_d       = j_q - AW'(1);
          mem_raddr = j_q - AW'(2);
          if (j_q - AW'(1) == k_q) begin
            state_d = S_SW;
          end
        end else begin
          if ({{(CW - AW){1'b0}}, i_q} + CW'(1) == n_q) begin
            state_d = S_ER;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_SI;
          end
        end
      end
      S_SW: begin
        mem_we = 1'b1;
        if ({{(CW - AW){1'b0}}, i_q} + CW'(1) == n_q) begin
          state_d = S_ER;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_SI;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      head_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      sum_q   <= sum_d;
    end
  end

  // Working registers of the sort and emit steps.
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    k_q   <= k_d;
    i_q   <= i_d;
    j_q   <= j_d;
    v_q   <= v_d;
    d_q   <= d_d;
    res_q <= res_d;
  end

  // The insertion point never drops below the first unserved entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC) |-> (j_q > k_q))
    else $error("insertion point at or below served region");

  // The sort index stays inside the batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SI) |-> (({{(CW - AW){1'b0}}, i_q} < n_q) && (i_q > k_q)))
    else $error("sort index outside batch");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == S_EM) && out_ready)
    else $error("result loaded while output busy");

  // After the final result the block returns to loading with a cleared request count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_q.last) |=> (state_q == S_LOAD) && (cnt_q == '0))
    else $error("batch did not close after final result");

endmodule

`default_nettype wire

/* tb/sstf_disk_request_order_test.sv */
// Self-checking testbench of the shortest seek time first request ordering block.
module sstf_disk_request_order_test;
  import sdro_pkg::*;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned StallLimit = 60000;
  localparam int unsigned DrainCycles = 40;

  // One expected result of the served order.
  typedef struct {
    logic [CylW-1:0]   served;
    logic [CylW-1:0]   seek;
    logic [TotalW-1:0] total;
    logic [TimeW-1:0]  time_ms;
    logic              last;
  } seek_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [MsW-1:0]      cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CylW-1:0]     s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // Predictor state: register copy, open batch and pending results.
  logic [MsW-1:0]  ms_per_cyl;
  logic [CylW-1:0] open_batch[$];
  seek_result_t    pending_seeks[$];
  int unsigned     error_count;
  bit              idling_on;
  int unsigned     hold_off_left;
  int unsigned     ready_stall_left;
  int unsigned     quiet_cycles;

  sstf_disk_request_order #(.MAX_REQUESTS(StoreDepth)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [CylW-1:0] cyl_gap(logic [CylW-1:0] a, logic [CylW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Orders a closed batch and queues its results in service order.
  task automatic schedule_batch();
    logic [CylW-1:0] order[StoreDepth];
    logic [CylW-1:0] head;
    logic [CylW-1:0] v;
    logic [22:0]     sum;
    logic [CylW-1:0] d;
    logic [36:0]     prod;
    seek_result_t    r;
    int              n;
    int              j;
    n = open_batch.size();
    for (int i = 0; i < n; i++) order[i] = open_batch[i];
    head = order[0];
    sum = '0;
    for (int k = 0; k < n; k++) begin
      // Stable insertion sort of the unserved tail by distance from the head.
      if (k > 0) begin
        for (int i = k + 1; i < n; i++) begin
          v = order[i];
          j = i;
          while (j > k && cyl_gap(order[j-1], head) > cyl_gap(v, head)) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = v;
        end
      end
      d = cyl_gap(order[k], head);
      sum = sum + d;
      if (sum > TotalLimit) sum = TotalLimit;
      head = order[k];
      prod = sum[TotalW-1:0] * ms_per_cyl;
      r.served = order[k];
      r.seek = d;
      r.total = sum[TotalW-1:0];
      r.time_ms = prod[TimeW-1:0];
      r.last = (k == n - 1);
      pending_seeks.push_back(r);
    end
    open_batch.delete();
  endtask

  // Sends one request; tvalid stays high into the next request unless a gap is taken.
  task automatic send_request(logic [CylW-1:0] cyl, logic last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cyl;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    open_batch.push_back(cyl);
    if (last || open_batch.size() == StoreDepth) schedule_batch();
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    while (pending_seeks.size() != 0 || open_batch.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_ms_per_cyl(logic [MsW-1:0] value);
    drop_valid();
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    ms_per_cyl = value;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Single requests, extreme cylinders and distance ties.
  task automatic test_directed();
    send_request(16'd0, 1'b1);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd100, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd150, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd10, 1'b0);
    send_request(16'd10, 1'b0);
    send_request(16'd20, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(16'd15, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b1);
  endtask

  // A full store closes the batch without tlast; the next request starts anew.
  task automatic test_full_store();
    for (int i = 0; i < StoreDepth; i++)
      send_request((i % 2) ? 16'(16'hFFFF - i) : 16'(i), 1'b0);
    send_request(16'h1234, 1'b1);
  endtask

  // One random batch, clustered, spread or extreme cylinders.
  task automatic send_random_batch(output int unsigned sent);
    int          n;
    int          mode;
    logic [15:0] base;
    logic [15:0] cyl;
    logic        last;
    n = ($urandom_range(0, 11) == 0) ? StoreDepth : $urandom_range(1, 8);
    mode = $urandom_range(0, 2);
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: cyl = 16'($urandom);
        1: cyl = base + 16'($urandom_range(0, 6));
        default: cyl = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
      last = (i == n - 1) ? ((n == StoreDepth) ? 1'($urandom) : 1'b1) : 1'b0;
      send_request(cyl, last);
    end
    sent = n;
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off_left = 400;
    for (int i = 0; i < 40; i++) send_request(16'($urandom), (i % 20) == 19);
    drop_valid();
    wait_idle();
  endtask

  task automatic test_random(int unsigned item_goal);
    int unsigned start;
    int unsigned sent;
    start = 0;
    while (start < item_goal) begin
      send_random_batch(sent);
      start += sent;
    end
  endtask

  // Receiver readiness: long hold-off first, then random stall bursts.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (ready_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      ready_stall_left <= ready_stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      ready_stall_left <= $urandom_range(1, 9) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    seek_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_seeks.size() == 0) begin
        $error("unexpected result transfer, tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        e = pending_seeks.pop_front();
        if (m_axis_tdata[15:0] !== e.served) begin
          $error("served_cylinder expected %0d actual %0d", e.served, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[31:16] !== e.seek) begin
          $error("seek_distance expected %0d actual %0d", e.seek, m_axis_tdata[31:16]);
          error_count++;
        end
        if (m_axis_tdata[52:32] !== e.total) begin
          $error("total_distance expected %0d actual %0d", e.total, m_axis_tdata[52:32]);
          error_count++;
        end
        if (m_axis_tdata[81:53] !== e.time_ms) begin
          $error("seek_time_ms expected %0d actual %0d", e.time_ms, m_axis_tdata[81:53]);
          error_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_result expected %0d actual %0d", e.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("sstf_disk_request_order regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    ms_per_cyl = MsReset;
    error_count = 0;
    idling_on = 1'b1;
    hold_off_left = 0;
    ready_stall_left = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_ms_per_cyl(8'd255);
    test_directed();
    write_ms_per_cyl(8'd0);
    test_full_store();
    write_ms_per_cyl(8'd255);
    test_full_store();
    test_backpressure();
    write_ms_per_cyl(8'($urandom));
    test_random(30);
    write_ms_per_cyl(8'd1);
    test_random(25);
    write_ms_per_cyl(MsReset);
    idling_on = 1'b0;
    test_random(20);

    drop_valid();
    wait_idle();
    if (error_count == 0) begin
      $display("sstf_disk_request_order regression: pass");
    end else begin
      $display("sstf_disk_request_order regression: fail");
    end
    $finish;
  end

endmodule
